@@ design/pvrg_pkg.sv @@
// ----------------------------------------------------------------------------
// pvrg_pkg: shared types and constants of the PIN verify retry guard
// Holds the command and status codes, the register indexes, the byte
// constants of the PIN format and the structs passed between the lanes,
// the merge stage and the top level.
// ----------------------------------------------------------------------------
package pvrg_pkg;

    localparam int LANES         = 8;
    localparam int MAX_PIN_BYTES = 8;
    localparam int MIN_PIN_BYTES = 6;

    localparam logic [63:0] PIN_VALUE_RESET    = 64'h3132_3334_3536_FFFF;
    localparam logic [3:0]  PIN_LENGTH_RESET   = 4'd6;
    localparam logic [19:0] WINDOW_TICKS_RESET = 20'd60000;
    localparam logic [3:0]  MAX_RETRIES_RESET  = 4'd3;

    localparam logic [7:0] QUAL_TWO_PIN    = 8'h80;
    localparam logic [7:0] QUAL_ONE_VERIFY = 8'h00;
    localparam logic [7:0] QUAL_ONE_LOGOUT = 8'hFF;
    localparam logic [7:0] PAD_BYTE        = 8'hFF;
    localparam logic [7:0] DIGIT_LOW       = 8'h30;
    localparam logic [7:0] DIGIT_HIGH      = 8'h39;

    typedef enum logic [1:0] {
        MODE_VERIFY  = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_RESTORE = 2'd2,
        MODE_CONSUME = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_QUAL     = 3'd1,
        ST_BLOCKED  = 3'd2,
        ST_RETRY    = 3'd3,
        ST_BAD_DATA = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_PIN_VALUE    = 2'd0,
        REG_PIN_LENGTH   = 2'd1,
        REG_WINDOW_TICKS = 2'd2,
        REG_MAX_RETRIES  = 2'd3
    } t_reg_idx;

    // What one byte lane finds about its byte.
    typedef struct packed {
        logic active;
        logic is_pad;
        logic is_digit;
        logic is_other;
        logic pin_eq;
    } t_lane_flags;

    // What the merge stage reports about the whole PIN field.
    typedef struct packed {
        logic       bad;
        logic [3:0] digits;
        logic       match;
    } t_pin_check;

endpackage

@@ design/pvrg_lane.sv @@
// ----------------------------------------------------------------------------
// pvrg_lane: one byte lane of the PIN check
// Classifies one data byte as padding, digit or other, and compares it
// with the stored PIN byte at the same position.
// ----------------------------------------------------------------------------
module pvrg_lane (
    input  logic                  i_active,
    input  logic [7:0]            i_data_byte,
    input  logic [7:0]            i_pin_byte,
    output pvrg_pkg::t_lane_flags o_flags
);
    import pvrg_pkg::*;

    logic w_pad;
    logic w_digit;

    assign w_pad   = (i_data_byte == PAD_BYTE);
    assign w_digit = (i_data_byte >= DIGIT_LOW) && (i_data_byte <= DIGIT_HIGH);

    always_comb begin
        o_flags.active   = i_active;
        o_flags.is_pad   = w_pad;
        o_flags.is_digit = w_digit;
        o_flags.is_other = !w_pad && !w_digit;
        o_flags.pin_eq   = (i_data_byte == i_pin_byte);
    end

endmodule

@@ design/pvrg_merge.sv @@
// ----------------------------------------------------------------------------
// pvrg_merge: combines the byte lanes into one PIN verdict
// Finds digits after padding or foreign bytes, counts the digits and
// decides whether the attempt matches the stored PIN and its length.
// ----------------------------------------------------------------------------
module pvrg_merge (
    input  pvrg_pkg::t_lane_flags i_flags [pvrg_pkg::LANES],
    input  logic [3:0]            i_pin_length,
    output pvrg_pkg::t_pin_check  o_check
);
    import pvrg_pkg::*;

    always_comb begin
        logic       padded;
        logic       bad;
        logic       bytes_eq;
        logic [3:0] digits;
        padded   = 1'b0;
        bad      = 1'b0;
        bytes_eq = 1'b1;
        digits   = 4'd0;
        for (int i = 0; i < LANES; i++) begin
            if (i_flags[i].active) begin
                if (i_flags[i].is_pad) begin
                    padded = 1'b1;
                end else if (i_flags[i].is_digit) begin
                    if (padded) begin
                        bad = 1'b1;
                    end
                    digits = digits + 4'd1;
                end else begin
                    bad = 1'b1;
                end
            end
            // Stored bytes past the stored length count as padding, and a
            // matching attempt has only padding or bytes past its count there, so
            // only the stored digits need comparing.
            if ((4'(i) < i_pin_length) && !i_flags[i].pin_eq) begin
                bytes_eq = 1'b0;
            end
        end
        o_check.bad    = bad;
        o_check.digits = digits;
        o_check.match  = bytes_eq && (i_pin_length == digits);
    end

endmodule

@@ design/pin_verify_retry_guard_unit.sv @@
// ----------------------------------------------------------------------------
// pin_verify_retry_guard_unit: PIN verify guard with retry counter
// Checks verify commands against a stored PIN, keeps the retry counter and
// the countdown of the verified window, and reports one status word for
// every command word.
// ----------------------------------------------------------------------------
// Usage:
//   Command words enter on the s_axis channel; tuser carries the mode
//   (verify, tick, restore, consume) and tdata the qualifiers and PIN data.
//   Every command word yields exactly one status word on m_axis.
//   The eight PIN bytes are checked at once by eight byte lanes and a merge
//   stage, so the guard state updates in the cycle a word is accepted and
//   its status word is registered in that same cycle.
//   Throughput is one word per cycle, limited only by the output channel.
//   When the receiver stalls, the pending status word holds on m_axis and
//   one more word is taken into a skid register; s_axis_tready drops only
//   while that skid register is full.
//   Reset (synchronous, active low) loads the default PIN "123456", length
//   6, a window of 60000 ticks and 3 retries, closes the window and empties
//   the output side. Registers are written through i_cfg_we / i_cfg_idx /
//   i_cfg_data, only while the block is idle: the user must keep to this; it is not enforced.
// ----------------------------------------------------------------------------
module pin_verify_retry_guard_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] qual_one, [15:8] qual_two, [16] data_present,
    // [17] data_malformed, [25:18] data_count, [89:26] pin_bytes, rest zero
    input  logic [95:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [6:3] retries_left, [7] is_verified
    output logic [7:0]  m_axis_tdata
);
    import pvrg_pkg::*;

    // Configuration registers.
    logic [63:0] r_pin_value;
    logic [3:0]  r_pin_length;
    logic [19:0] r_window_ticks;
    logic [3:0]  r_max_retries;

    // Guard state.
    logic [3:0]  r_retry_count, n_retry_count;
    logic [19:0] r_remaining,   n_remaining;

    // Output register and skid stage.
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_data,  n_out_data;
    logic        r_skid_valid, n_skid_valid;
    logic [7:0]  r_skid_data,  n_skid_data;

    // Unpacked command fields.
    logic [7:0]  w_qual_one;
    logic [7:0]  w_qual_two;
    logic        w_present;
    logic        w_malformed;
    logic [7:0]  w_count;
    logic [63:0] w_pin_bytes;
    t_mode       w_mode;

    logic        w_accept;
    t_status     w_status;
    logic [7:0]  w_result;

    t_lane_flags w_flags [LANES];
    t_pin_check  w_check;

    assign w_qual_one  = s_axis_tdata[7:0];
    assign w_qual_two  = s_axis_tdata[15:8];
    assign w_present   = s_axis_tdata[16];
    assign w_malformed = s_axis_tdata[17];
    assign w_count     = s_axis_tdata[25:18];
    assign w_pin_bytes = s_axis_tdata[89:26];
    assign w_mode      = t_mode'(s_axis_tuser);

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Lane 0 holds the first PIN byte, which sits in the top byte.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        pvrg_lane u_lane (
            .i_active    (w_count > 8'(g)),
            .i_data_byte (w_pin_bytes[63 - 8*g -: 8]),
            .i_pin_byte  (r_pin_value[63 - 8*g -: 8]),
            .o_flags     (w_flags[g])
        );
    end

    pvrg_merge u_merge (
        .i_flags      (w_flags),
        .i_pin_length (r_pin_length),
        .o_check      (w_check)
    );

    always_comb begin
        logic [3:0] dec_retry;
        dec_retry     = r_retry_count - 4'd1;
        n_retry_count = r_retry_count;
        n_remaining   = r_remaining;
        w_status      = ST_OK;
        case (w_mode)
            MODE_VERIFY: begin
                if (w_qual_two != QUAL_TWO_PIN) begin
                    n_remaining = '0;
                    w_status    = ST_QUAL;
                end else if (w_qual_one == QUAL_ONE_LOGOUT) begin
                    n_remaining = '0;
                end else if (w_qual_one != QUAL_ONE_VERIFY) begin
                    n_remaining = '0;
                    w_status    = ST_QUAL;
                end else if (!w_present) begin
                    // A bare verify only reports where the guard stands.
                    if (r_retry_count == 4'd0) begin
                        w_status = ST_BLOCKED;
                    end else if (r_remaining == '0) begin
                        w_status = ST_RETRY;
                    end
                end else if (w_malformed) begin
                    n_remaining = '0;
                    w_status    = ST_QUAL;
                end else if (r_retry_count == 4'd0) begin
                    n_remaining = '0;
                    w_status    = ST_BLOCKED;
                end else if ((w_count < 8'(MIN_PIN_BYTES)) ||
                             (w_count > 8'(MAX_PIN_BYTES))) begin
                    n_remaining = '0;
                    w_status    = ST_BAD_DATA;
                end else if (w_check.bad || (w_check.digits < 4'(MIN_PIN_BYTES))) begin
                    n_remaining = '0;
                    w_status    = ST_BAD_DATA;
                end else if (w_check.match) begin
                    n_retry_count = r_max_retries;
                    n_remaining   = r_window_ticks;
                end else begin
                    n_remaining   = '0;
                    n_retry_count = dec_retry;
                    w_status      = (dec_retry == 4'd0) ? ST_BLOCKED : ST_RETRY;
                end
            end
            MODE_TICK: begin
                if (r_remaining != '0) begin
                    n_remaining = r_remaining - 20'd1;
                end
            end
            MODE_RESTORE: begin
                n_retry_count = r_max_retries;
            end
            MODE_CONSUME: begin
                n_remaining = '0;
            end
            default: begin
                n_remaining = r_remaining;
            end
        endcase
    end

    assign w_result = {(n_remaining != '0), n_retry_count, w_status};

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (m_axis_tready || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_accept;
                n_out_data  = w_result;
            end
        end else if (w_accept) begin
            // Output is stalled: park the new word in the skid register.
            n_skid_valid = 1'b1;
            n_skid_data  = w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_value    <= PIN_VALUE_RESET;
            r_pin_length   <= PIN_LENGTH_RESET;
            r_window_ticks <= WINDOW_TICKS_RESET;
            r_max_retries  <= MAX_RETRIES_RESET;
            r_retry_count  <= MAX_RETRIES_RESET;
            r_remaining    <= '0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_PIN_VALUE:    r_pin_value    <= i_cfg_data;
                    REG_PIN_LENGTH:   r_pin_length   <= i_cfg_data[3:0];
                    REG_WINDOW_TICKS: r_window_ticks <= i_cfg_data[19:0];
                    REG_MAX_RETRIES:  r_max_retries  <= i_cfg_data[3:0];
                    default:          r_pin_value    <= r_pin_value;
                endcase
            end
            if (w_accept) begin
                r_retry_count <= n_retry_count;
                r_remaining   <= n_remaining;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

endmodule

@@ dv/tb_pin_verify_retry_guard_unit.sv @@
// ----------------------------------------------------------------------------
// tb_pin_verify_retry_guard_unit: stream test of the PIN verify retry guard
// Drives command words with random gaps, stalls the status channel at random
// and checks every status word against its directed table entry or a software
// copy of the guard. A short table of directed words comes first, then random
// words under several register settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_pin_verify_retry_guard_unit;
    import pvrg_pkg::*;

    localparam int QUIET_LIMIT = 500;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  qual_one;
        logic [7:0]  qual_two;
        logic        present;
        logic        malformed;
        logic [7:0]  count;
        logic [63:0] pin;
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic [3:0] retries;
        logic       verified;
    } t_result;

    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    // Software copy of the guard: its registers and its state.
    logic [63:0] stored_pin;
    logic [3:0]  stored_len;
    logic [19:0] window_len;
    logic [3:0]  retry_limit;
    logic [3:0]  retries;
    logic [19:0] window_left;

    t_result due_status[$];
    t_row    directed_rows[$];
    int      mismatches;
    bit      calm;

    pin_verify_retry_guard_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Bytes at index keep and beyond (first byte is index 0) read as padding.
    function automatic logic [63:0] pad_ff(input logic [63:0] v, input int keep);
        if (keep >= 8) begin
            return v;
        end
        return v | ({64{1'b1}} >> (keep * 8));
    endfunction

    function automatic t_result guard_step(input t_cmd c);
        t_result    r;
        int         digits;
        int         i;
        bit         padded;
        bit         bad;
        logic [7:0] b;
        r.status = ST_OK;
        case (c.mode)
            MODE_VERIFY: begin
                if (c.qual_two != QUAL_TWO_PIN) begin
                    window_left = '0;
                    r.status = ST_QUAL;
                end else if (c.qual_one == QUAL_ONE_LOGOUT) begin
                    window_left = '0;
                end else if (c.qual_one != QUAL_ONE_VERIFY) begin
                    window_left = '0;
                    r.status = ST_QUAL;
                end else if (!c.present) begin
                    // A bare verify only asks for the state; nothing changes.
                    if (retries == 0) r.status = ST_BLOCKED;
                    else if (window_left == 0) r.status = ST_RETRY;
                end else if (c.malformed) begin
                    window_left = '0;
                    r.status = ST_QUAL;
                end else if (retries == 0) begin
                    window_left = '0;
                    r.status = ST_BLOCKED;
                end else if (c.count < MIN_PIN_BYTES || c.count > MAX_PIN_BYTES) begin
                    window_left = '0;
                    r.status = ST_BAD_DATA;
                end else begin
                    digits = 0;
                    padded = 1'b0;
                    bad = 1'b0;
                    for (i = 0; i < c.count; i++) begin
                        b = c.pin[63 - 8 * i -: 8];
                        if (b == PAD_BYTE) padded = 1'b1;
                        else if (padded || b < DIGIT_LOW || b > DIGIT_HIGH) bad = 1'b1;
                        else digits++;
                    end
                    if (bad || digits < MIN_PIN_BYTES) begin
                        window_left = '0;
                        r.status = ST_BAD_DATA;
                    end else if (stored_len == digits &&
                                 pad_ff(c.pin, digits) == pad_ff(stored_pin, stored_len)) begin
                        retries = retry_limit;
                        window_left = window_len;
                    end else begin
                        window_left = '0;
                        retries = retries - 4'd1;
                        r.status = (retries == 0) ? ST_BLOCKED : ST_RETRY;
                    end
                end
            end
            MODE_TICK: begin
                if (window_left != 0) window_left = window_left - 20'd1;
            end
            MODE_RESTORE: retries = retry_limit;
            default: window_left = '0;
        endcase
        r.retries = retries;
        r.verified = (window_left != 0);
        return r;
    endfunction

    function automatic t_cmd verify_word(input logic [7:0] q1, input logic [7:0] q2,
                                         input logic present, input logic malformed,
                                         input logic [7:0] count, input logic [63:0] pin);
        t_cmd c;
        c.mode = MODE_VERIFY;
        c.qual_one = q1;
        c.qual_two = q2;
        c.present = present;
        c.malformed = malformed;
        c.count = count;
        c.pin = pin;
        return c;
    endfunction

    function automatic void add_row(input t_cmd c, input bit typed, input t_status st,
                                    input logic [3:0] rt, input logic ver);
        t_row row;
        row.cmd = c;
        row.typed = typed;
        row.want.status = st;
        row.want.retries = rt;
        row.want.verified = ver;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [63:0] digit_pin(input int len);
        logic [63:0] v;
        int          k;
        v = {$urandom, $urandom};
        for (k = 0; k < len; k++) begin
            v[63 - 8 * k -: 8] = DIGIT_LOW + 8'($urandom_range(0, 9));
        end
        return v;
    endfunction

    function automatic t_cmd random_word();
        t_cmd c;
        int   pick;
        int   keep;
        int   len;
        int   k;
        c.mode = t_mode'($urandom_range(0, 3));
        c.qual_one = 8'($urandom);
        c.qual_two = 8'($urandom);
        c.present = 1'($urandom);
        c.malformed = 1'($urandom);
        c.count = 8'($urandom);
        c.pin = {$urandom, $urandom};
        keep = (stored_len < 1) ? 1 : ((stored_len > 8) ? 8 : stored_len);
        pick = $urandom_range(0, 99);
        if (pick < 36) begin
            c.mode = (pick < 20) ? MODE_TICK : ((pick < 28) ? MODE_RESTORE : MODE_CONSUME);
        end else begin
            c.mode = MODE_VERIFY;
            if (pick < 90) begin
                c.qual_one = QUAL_ONE_VERIFY;
                c.qual_two = QUAL_TWO_PIN;
                c.present = 1'b1;
                c.malformed = 1'b0;
            end
            if (pick < 78) begin
                // Well-formed attempt: the stored PIN, a near miss of it, or random digits,
                // padded up to the count and followed by random bytes.
                len = (pick < 70) ? keep : $urandom_range(6, 8);
                c.count = 8'($urandom_range(len, 8));
                for (k = 0; k < 8; k++) begin
                    if (k < len) begin
                        c.pin[63 - 8 * k -: 8] = (pick < 70) ? stored_pin[63 - 8 * k -: 8]
                                                            : DIGIT_LOW + 8'($urandom_range(0, 9));
                    end else if (k < c.count) begin
                        c.pin[63 - 8 * k -: 8] = PAD_BYTE;
                    end
                end
                if (pick >= 56 && pick < 70) begin
                    k = $urandom_range(0, len - 1);
                    c.pin[63 - 8 * k -: 8] = DIGIT_LOW +
                        8'((int'(c.pin[63 - 8 * k -: 8]) - 48 + $urandom_range(1, 9)) % 10);
                end
            end else if (pick < 82) begin
                c.present = 1'b0;
            end else if (pick < 86) begin
                c.qual_one = QUAL_ONE_LOGOUT;
            end else if (pick < 90) begin
                c.malformed = 1'b1;
            end else if (pick < 96) begin
                // Short noisy PIN fields: digits, padding and junk mixed.
                c.qual_one = QUAL_ONE_VERIFY;
                c.qual_two = QUAL_TWO_PIN;
                c.present = 1'b1;
                c.malformed = 1'b0;
                c.count = 8'($urandom_range(0, 10));
                for (k = 0; k < 8; k++) begin
                    case ($urandom_range(0, 2))
                        0: c.pin[63 - 8 * k -: 8] = DIGIT_LOW + 8'($urandom_range(0, 9));
                        1: c.pin[63 - 8 * k -: 8] = PAD_BYTE;
                        default: ;
                    endcase
                end
            end
        end
        return c;
    endfunction

    task automatic push_cmd(input t_cmd c, input bit typed, input t_result given);
        int      gap;
        t_result r;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, c.pin, c.count, c.malformed, c.present, c.qual_two, c.qual_one};
        s_axis_tuser <= c.mode;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        r = guard_step(c);
        due_status.push_back(typed ? given : r);
    endtask

    // Ends a burst of words and lets every status word come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (due_status.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic configure(input logic [63:0] pin, input logic [3:0] len,
                             input logic [19:0] win, input logic [3:0] limit);
        logic [63:0] vals[4];
        int          r;
        vals[0] = pin;
        vals[1] = {60'd0, len};
        vals[2] = {44'd0, win};
        vals[3] = {60'd0, limit};
        i_cfg_we <= 1'b1;
        for (r = 0; r < 4; r++) begin
            i_cfg_idx <= t_reg_idx'(r);
            i_cfg_data <= vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        stored_pin = pin;
        stored_len = len;
        window_len = win;
        retry_limit = limit;
    endtask

    task automatic run_words(input int n);
        repeat (n) push_cmd(random_word(), 1'b0, '0);
        drain();
    endtask

    // Status side: random stalls, every accepted word checked in order.
    initial begin : status_side
        int      stall;
        t_result want;
        m_axis_tready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            if (due_status.size() == 0) begin
                note_mismatch($sformatf("status word %h with nothing expected", m_axis_tdata));
            end else begin
                want = due_status.pop_front();
                if (m_axis_tdata[2:0] !== want.status)
                    note_mismatch($sformatf("status %0d, expected %0d",
                                            m_axis_tdata[2:0], want.status));
                if (m_axis_tdata[6:3] !== want.retries)
                    note_mismatch($sformatf("retries_left %0d, expected %0d",
                                            m_axis_tdata[6:3], want.retries));
                if (m_axis_tdata[7] !== want.verified)
                    note_mismatch($sformatf("is_verified %b, expected %b",
                                            m_axis_tdata[7], want.verified));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
                (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) quiet = 0;
            else quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : main_flow
        int n;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_PIN_VALUE;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_VERIFY;
        mismatches = 0;
        calm = 1'b0;
        stored_pin = PIN_VALUE_RESET;
        stored_len = PIN_LENGTH_RESET;
        window_len = WINDOW_TICKS_RESET;
        retry_limit = MAX_RETRIES_RESET;
        retries = MAX_RETRIES_RESET;
        window_left = '0;

        // Directed words under the reset settings, PIN "123456".
        add_row(verify_word(8'h00, 8'h80, 1'b0, 1'b0, 8'd0, 64'h0), 1, ST_RETRY, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd6, 64'h3132_3334_3536_FFFF),
                1, ST_OK, 4'd3, 1'b1);
        add_row(verify_word(8'h00, 8'h80, 1'b0, 1'b0, 8'd0, 64'h0), 1, ST_OK, 4'd3, 1'b1);
        add_row('{MODE_TICK, 8'h0, 8'h0, 1'b0, 1'b0, 8'h0, 64'h0}, 1, ST_OK, 4'd3, 1'b1);
        add_row('{MODE_CONSUME, 8'h0, 8'h0, 1'b0, 1'b0, 8'h0, 64'h0}, 1, ST_OK, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd8, 64'h3132_3334_3536_FFFF),
                1, ST_OK, 4'd3, 1'b1);
        add_row(verify_word(8'h00, 8'h00, 1'b1, 1'b0, 8'd6, 64'h3132_3334_3536_FFFF),
                1, ST_QUAL, 4'd3, 1'b0);
        // Bytes past the count do not take part in the compare.
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd6, 64'h3132_3334_3536_0000),
                1, ST_OK, 4'd3, 1'b1);
        add_row(verify_word(8'hFF, 8'h80, 1'b1, 1'b0, 8'd6, 64'h0), 1, ST_OK, 4'd3, 1'b0);
        add_row(verify_word(8'h01, 8'h80, 1'b1, 1'b0, 8'd6, 64'h0), 1, ST_QUAL, 4'd3, 1'b0);
        add_row(verify_word(8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, {64{1'b1}}),
                1, ST_QUAL, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b1, 8'd6, 64'h3132_3334_3536_FFFF),
                1, ST_QUAL, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd5, 64'h3132_3334_35FF_FFFF),
                1, ST_BAD_DATA, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd9, 64'h3132_3334_3536_FFFF),
                1, ST_BAD_DATA, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'hFF, {64{1'b1}}),
                1, ST_BAD_DATA, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd0, 64'h0), 1, ST_BAD_DATA, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd8, 64'h0), 1, ST_BAD_DATA, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd6, 64'h3132_3334_353A_FFFF),
                1, ST_BAD_DATA, 4'd3, 1'b0);
        // A digit after padding, then too few digits before padding.
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd8, 64'h3132_3334_35FF_36FF),
                1, ST_BAD_DATA, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd8, 64'h3132_3334_35FF_FFFF),
                1, ST_BAD_DATA, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd6, 64'h3132_3334_3537_FFFF),
                1, ST_RETRY, 4'd2, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd7, 64'h3132_3334_3536_37FF),
                1, ST_RETRY, 4'd1, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd8, 64'h3939_3939_3939_3939),
                1, ST_BLOCKED, 4'd0, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd6, 64'h3132_3334_3536_FFFF),
                1, ST_BLOCKED, 4'd0, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b0, 1'b0, 8'd0, 64'h0), 1, ST_BLOCKED, 4'd0, 1'b0);
        add_row('{MODE_RESTORE, 8'h0, 8'h0, 1'b0, 1'b0, 8'h0, 64'h0}, 1, ST_OK, 4'd3, 1'b0);
        add_row(verify_word(8'h00, 8'h80, 1'b1, 1'b0, 8'd7, 64'h3132_3334_3536_FF00),
                0, ST_OK, 4'd0, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < directed_rows.size(); n++) begin
            push_cmd(directed_rows[n].cmd, directed_rows[n].typed, directed_rows[n].want);
        end
        drain();

        configure(digit_pin(8), 4'd8, 20'd1, 4'd15);
        run_words(400);
        configure(digit_pin(7), 4'd7, 20'hFFFFF, 4'd1);
        run_words(400);
        calm = 1'b1;
        configure(digit_pin(6), 4'd6, 20'($urandom_range(1, 8)), 4'($urandom_range(1, 15)));
        run_words(350);
        calm = 1'b0;
        // A stored length no attempt can have, and no retries given back by restore.
        configure({64{1'b1}}, 4'hF, 20'd3, 4'd0);
        run_words(150);
        configure(64'h0, 4'd6, 20'd20, 4'd15);
        run_words(100);
        configure(digit_pin(6), 4'd6, 20'($urandom_range(1, 50)), 4'd3);
        run_words(400);

        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
